[rtl/refcounted_double_hash_table_macros.svh]
// assertion helpers for the refcounted double hash table
`ifndef REFCOUNTED_DOUBLE_HASH_TABLE_MACROS_SVH
`define REFCOUNTED_DOUBLE_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define RCDHT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcdht assertion failed");
// next-cycle implication, checked outside reset
`define RCDHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcdht assertion failed");
`else
`define RCDHT_ASSERT(lbl, ante, cons)
`define RCDHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/rcdht_pkg.sv]
`default_nettype none

package rcdht_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned KeyW      = 32;
  localparam int unsigned CntW      = 32;
  localparam int unsigned SlotW     = 10;
  localparam int unsigned StatusW   = 2;

  // input beat: key_hash, release_when_unused
  localparam int unsigned InFieldW  = KeyW + 1;
  localparam int unsigned InTdataW  = ((InFieldW + 7) / 8) * 8;
  // output beat: status, slot_index, use_count, auto_release_flag, half_load_exceeded
  localparam int unsigned OutFieldW = StatusW + SlotW + CntW + 2;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;

  typedef enum logic [StatusW-1:0] {
    STAT_FOUND    = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            valid;
    logic            auto_rel;
    logic [CntW-1:0] count;
    logic [KeyW-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

[rtl/refcounted_double_hash_table.sv]
// one item at a time: a new input beat is taken only once the last item's result is registered
//   at the output; p = number of slots probed (1..1024), each probe is one read and one compare on the
//   slot memory, the probe address advanced by one shared 10-bit adder
// reset: rst_ni is asynchronous, active low; afterwards a clearing pass over all 1024 slots
//   marks every slot empty, and tready stays low until it is done
`default_nettype none

module refcounted_double_hash_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // key_hash [31:0], release_when_unused [32], zero pad above
  input  logic [rcdht_pkg::InTdataW-1:0] s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // status [1:0], slot_index [11:2], use_count [43:12], auto_release_flag [44],
  // half_load_exceeded [45], zero pad above
  output logic [rcdht_pkg::OutTdataW-1:0] m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);
  import rcdht_pkg::*;

  `include "refcounted_double_hash_table_macros.svh"

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);
  localparam logic [IdxW:0]   HalfLoad = (IdxW + 1)'(TableSize / 2);

  // slot memory: valid, auto-release, count and key in one word
  entry_t mem [TableSize];
  entry_t rd_q;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;

  state_e state_q, state_d;

  logic [KeyW-1:0] key_q, key_d;
  logic            keep_q, keep_d;
  logic [IdxW-1:0] probe_q, probe_d;   // current probe slot
  logic [IdxW-1:0] step_q, step_d;     // probe number within this item
  logic [IdxW-1:0] clr_q, clr_d;       // clearing pass pointer
  logic [IdxW:0]   occ_q, occ_d;       // occupied slot count
  entry_t          ent_q, ent_d;       // updated entry waiting to be written
  status_e         stat_q, stat_d;

  logic                 out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  logic            in_beat;
  logic            out_free;
  logic [IdxW-1:0] stride;
  logic            hit;
  logic            is_full;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  // odd stride, so the probe walk visits every slot of the power-of-two table
  assign stride   = IdxW'({key_q, 1'b1});
  assign hit      = rd_q.valid && (rd_q.key == key_q);
  assign is_full  = (stat_q == STAT_FULL);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // memory: one write port, one registered read at the probe slot
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[probe_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    keep_q     <= keep_d;
    probe_q    <= probe_d;
    step_q     <= step_d;
    ent_q      <= ent_d;
    stat_q     <= stat_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    keep_d      = keep_q;
    probe_d     = probe_q;
    step_d      = step_q;
    clr_d       = clr_q;
    occ_d       = occ_q;
    ent_d       = ent_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = probe_q;
    wdata       = ent_q;

    case (state_q)
      ST_CLEAR: begin
        // mark every slot empty, one per cycle
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          key_d   = s_axis_tdata_i[KeyW-1:0];
          keep_d  = s_axis_tdata_i[KeyW];
          probe_d = s_axis_tdata_i[IdxW-1:0];
          step_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // memory read of probe_q is in flight
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          stat_d         = STAT_FOUND;
          ent_d          = rd_q;
          ent_d.auto_rel = rd_q.auto_rel && keep_q;
          ent_d.count    = (rd_q.count == '1) ? rd_q.count : rd_q.count + 1'b1;
          state_d        = ST_WRITE;
        end else if (!rd_q.valid) begin
          // empty slot: insert, count starts at one
          stat_d         = STAT_INSERTED;
          ent_d.valid    = 1'b1;
          ent_d.auto_rel = keep_q;
          ent_d.count    = CntW'(1);
          ent_d.key      = key_q;
          occ_d          = occ_q + 1'b1;
          state_d        = ST_WRITE;
        end else if (step_q == LastIdx) begin
          stat_d  = STAT_FULL;
          state_d = ST_DONE;
        end else begin
          probe_d = probe_q + stride;
          step_d  = step_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_WRITE, ST_DONE: begin
        if (out_free) begin
          we          = (state_q == ST_WRITE);
          out_valid_d = 1'b1;
          out_data_d  = OutTdataW'({
                          (occ_q > HalfLoad),
                          (is_full ? 1'b0 : ent_q.auto_rel),
                          (is_full ? {CntW{1'b0}} : ent_q.count),
                          (is_full ? {SlotW{1'b0}} : SlotW'(probe_q)),
                          stat_q});
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // no input beat is taken while the clearing pass runs
  `RCDHT_ASSERT(a_no_accept_in_clear, state_q == ST_CLEAR, !s_axis_tready_o)
  // occupancy can never exceed the table
  `RCDHT_ASSERT(a_occ_bounded, 1'b1, occ_q <= (IdxW + 1)'(TableSize))
  // a refused request reports slot, count and flag as zero
  `RCDHT_ASSERT(a_full_zero, m_axis_tvalid_o && m_axis_tdata_o[StatusW-1:0] == STAT_FULL,
                m_axis_tdata_o[StatusW+SlotW+CntW:StatusW] == '0)
  // one item at a time: after an input beat the block is busy
  `RCDHT_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready_o)

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rcdht_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;

  typedef struct {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  count;
    logic             auto_rel;
    logic             half_load;
  } acquire_result_t;

  logic                 clk_i;
  logic                 rst_ni   = 1'b0;
  logic [InTdataW-1:0]  s_tdata  = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OutTdataW-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;

  // shadow copy of the slot table, updated as each acquire beat is accepted
  bit              tbl_valid   [TableSize];
  logic [KeyW-1:0] tbl_key     [TableSize];
  logic [CntW-1:0] tbl_count   [TableSize];
  bit              tbl_autorel [TableSize];
  int unsigned     tbl_used = 0;

  acquire_result_t pending_results[$];
  logic [KeyW-1:0] issued_keys[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;

  refcounted_double_hash_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // walks the double-hash chain, inserts on the first empty slot, bumps the count
  function automatic acquire_result_t predict_acquire(input logic [KeyW-1:0] key,
                                                      input logic keep);
    acquire_result_t r;
    logic [KeyW-1:0] stride;
    logic [KeyW-1:0] pos;
    logic [IdxW-1:0] idx;
    bit              hit;
    int              step;
    r.status   = STAT_FULL;
    r.slot     = '0;
    r.count    = '0;
    r.auto_rel = 1'b0;
    stride     = {key[KeyW-2:0], 1'b1};
    hit        = 1'b0;
    idx        = '0;
    for (step = 0; step < TableSize && !hit; step++) begin
      pos = key + step * stride;
      idx = pos[IdxW-1:0];
      // an empty slot is never a match, whatever key it last held
      if (!tbl_valid[idx]) begin
        tbl_valid[idx]   = 1'b1;
        tbl_key[idx]     = key;
        tbl_count[idx]   = '0;
        tbl_autorel[idx] = 1'b1;
        tbl_used++;
        r.status = STAT_INSERTED;
        hit      = 1'b1;
      end else if (tbl_key[idx] == key) begin
        r.status = STAT_FOUND;
        hit      = 1'b1;
      end
    end
    if (hit) begin
      if (!keep) tbl_autorel[idx] = 1'b0;
      // count saturates at all ones
      if (tbl_count[idx] != '1) tbl_count[idx]++;
      r.slot     = idx;
      r.count    = tbl_count[idx];
      r.auto_rel = tbl_autorel[idx];
    end
    r.half_load = (tbl_used > TableSize / 2);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // both sides sampled at the rising edge: result beat checked first, then the
  // accepted acquire beat is predicted (a result never leaves in its own cycle)
  always @(posedge clk_i) begin : beat_monitor
    acquire_result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no acquire pending: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
          check_field("slot_index", 32'(want.slot), 32'(m_tdata[11:2]));
          check_field("use_count", want.count, m_tdata[43:12]);
          check_field("auto_release_flag", 32'(want.auto_rel), 32'(m_tdata[44]));
          check_field("half_load_exceeded", 32'(want.half_load), 32'(m_tdata[45]));
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_acquire(s_tdata[KeyW-1:0], s_tdata[KeyW]));
    end
  end

  // result sink: random idling, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= !(sink_idle_on && $urandom_range(99) < 20);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_acquire(input logic [KeyW-1:0] key, input logic keep);
    @(negedge clk_i);
    if (src_idle_on && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 20);
    end
    s_tdata  <= {{(InTdataW - KeyW - 1){1'b0}}, keep, key};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // mostly keys already in the table, some fresh ones, some that share the
  // home slot of a known key so the probe chains grow
  function automatic logic [KeyW-1:0] choose_key();
    logic [KeyW-1:0] k;
    int unsigned     roll;
    roll = $urandom_range(99);
    if (issued_keys.size() != 0 && roll < 55) begin
      k = issued_keys[$urandom_range(issued_keys.size() - 1)];
    end else begin
      k = $urandom;
      if (issued_keys.size() != 0 && roll < 75)
        k[IdxW-1:0] = issued_keys[$urandom_range(issued_keys.size() - 1)][IdxW-1:0];
      issued_keys.push_back(k);
    end
    return k;
  endfunction

  task automatic test_directed();
    send_acquire(32'h0000_0000, 1'b1);  // fresh table: inserted, not matched
    send_acquire(32'h0000_0000, 1'b1);  // found, count two
    send_acquire(32'h0000_0000, 1'b0);  // auto-release cleared
    send_acquire(32'h0000_0000, 1'b1);  // a keep request does not set it again
    send_acquire(32'hFFFF_FFFF, 1'b0);  // top slot, inserted with auto-release off
    send_acquire(32'h0000_0400, 1'b1);  // same home slot as key zero
    send_acquire(32'h0000_0800, 1'b1);  // third in that chain
    send_acquire(32'h0000_0400, 1'b0);  // found down the chain
    send_acquire(32'h8000_0000, 1'b1);  // stride wraps to one
    send_acquire(32'hAAAA_AAAA, 1'b0);
    send_acquire(32'h5555_5555, 1'b1);
    send_acquire(32'h0000_0800, 1'b0);
    send_acquire(32'hFFFF_FFFF, 1'b1);
    send_acquire(32'h8000_0000, 1'b0);
    issued_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0400, 32'h0000_0800,
                    32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    drain_results();
  endtask

  task automatic test_random_mix(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      send_acquire(choose_key(), 1'($urandom_range(1)));
      if ($urandom_range(99) < 2) drain_results();
    end
    drain_results();
  endtask

  // results held back long enough for the block to stop taking beats
  task automatic test_output_backpressure();
    int i;
    @(posedge clk_i);
    stall_left = 400;
    for (i = 0; i < 12; i++) send_acquire(choose_key(), 1'($urandom_range(1)));
    drain_results();
  endtask

  task automatic test_no_idle_burst(input int unsigned n);
    int unsigned i;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (i = 0; i < n; i++) send_acquire(choose_key(), 1'($urandom_range(1)));
    drain_results();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // mostly fresh keys until every slot is taken, crossing the half-load mark
  task automatic test_fill_to_full();
    logic [KeyW-1:0] k;
    while (tbl_used < TableSize) begin
      if ($urandom_range(99) < 10) begin
        k = issued_keys[$urandom_range(issued_keys.size() - 1)];
      end else begin
        k = $urandom;
        issued_keys.push_back(k);
      end
      send_acquire(k, 1'($urandom_range(1)));
    end
    drain_results();
  endtask

  // absent keys are refused once the table is full, present ones still found
  task automatic test_full_table();
    int i;
    for (i = 0; i < 20; i++) begin
      if (i % 2 == 0) send_acquire($urandom, 1'($urandom_range(1)));
      else send_acquire(issued_keys[$urandom_range(issued_keys.size() - 1)],
                        1'($urandom_range(1)));
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix(1000);
    test_output_backpressure();
    test_no_idle_burst(200);
    test_fill_to_full();
    test_full_table();
    drain_results();
    repeat (2 * TableSize + 8) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
